// ----- src/ifp_pkg.sv -----
// Shared types and constants for the IMU frame parser and reporter.
// Used by every module of the block; depends on nothing.
package ifp_pkg;

   localparam logic [1:0] MODE_RX    = 2'd0;
   localparam logic [1:0] MODE_ACCEL = 2'd1;
   localparam logic [1:0] MODE_RATE  = 2'd2;
   localparam logic [1:0] MODE_ANGLE = 2'd3;

   localparam logic [7:0] HDR_BYTE    = 8'h55;
   localparam logic [7:0] TAIL_BYTE   = 8'hBB;
   localparam logic [7:0] LEN_BYTE    = 8'h06;
   localparam logic [7:0] TYPE_ACCEL  = 8'h51;
   localparam logic [7:0] TYPE_RATE   = 8'h52;
   localparam logic [7:0] TYPE_ANGLE  = 8'h53;
   localparam logic [7:0] ID_ACCEL    = 8'h03;
   localparam logic [7:0] ID_RATE     = 8'h04;
   localparam logic [7:0] ID_ANGLE    = 8'h05;

   localparam logic [3:0] FRAME_LAST  = 4'd10;

   // Byte positions within an outgoing report.
   localparam logic [3:0] POS_HDR  = 4'd0;
   localparam logic [3:0] POS_ID   = 4'd1;
   localparam logic [3:0] POS_LEN  = 4'd2;
   localparam logic [3:0] POS_D0   = 4'd3;
   localparam logic [3:0] POS_D1   = 4'd4;
   localparam logic [3:0] POS_D2   = 4'd5;
   localparam logic [3:0] POS_D3   = 4'd6;
   localparam logic [3:0] POS_D4   = 4'd7;
   localparam logic [3:0] POS_D5   = 4'd8;
   localparam logic [3:0] POS_SUM  = 4'd9;
   localparam logic [3:0] POS_TAIL = 4'd10;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } rsp_type;

   // One pending report: which store, and its three values as taken.
   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] data;
   } rpt_type;

endpackage

// ----- src/ifp_front.sv -----
// Front end: accepts requests, assembles received frames into the three
// value stores and queues snapshots for report requests. Uses ifp_pkg.
module ifp_front import ifp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  logic    q_full,
   output logic    q_push,
   output rpt_type q_push_data
);

   logic [3:0]       count_ff, count_in;
   logic [7:0]       frame_ff [1:7];
   logic [2:0][15:0] accel_ff, accel_in;
   logic [2:0][15:0] rate_ff, rate_in;
   logic [2:0][15:0] angle_ff, angle_in;
   logic [47:0]      triplet;
   logic             accept;
   logic             rx_take;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign rx_take   = accept && (req_payload.mode == MODE_RX);
   assign q_push    = accept && (req_payload.mode != MODE_RX);

   // Bytes 2..7 of the frame, already little-endian per axis.
   assign triplet = {frame_ff[7], frame_ff[6], frame_ff[5],
                     frame_ff[4], frame_ff[3], frame_ff[2]};

   always_comb begin
      q_push_data.kind = req_payload.mode;
      case (req_payload.mode)
         MODE_ACCEL: q_push_data.data = accel_ff;
         MODE_RATE:  q_push_data.data = rate_ff;
         default:    q_push_data.data = angle_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      accel_in = accel_ff;
      rate_in  = rate_ff;
      angle_in = angle_ff;
      if (rx_take) begin
         if (count_ff == 4'd0 && req_payload.rx_byte != HDR_BYTE) begin
            count_in = 4'd0;
         end else if (count_ff == FRAME_LAST) begin
            count_in = 4'd0;
            case (frame_ff[1])
               TYPE_ACCEL: accel_in = triplet;
               TYPE_RATE:  rate_in  = triplet;
               TYPE_ANGLE: angle_in = triplet;
               default: ;
            endcase
         end else begin
            count_in = count_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         accel_ff <= '0;
         rate_ff  <= '0;
         angle_ff <= '0;
      end else begin
         count_ff <= count_in;
         accel_ff <= accel_in;
         rate_ff  <= rate_in;
         angle_ff <= angle_in;
      end
   end

   // The header byte itself need not be kept: a non-zero count implies it.
   always_ff @(posedge clock) begin
      for (int i = 1; i <= 7; i++) begin
         if (rx_take && count_ff == 4'(i)) begin
            frame_ff[i] <= req_payload.rx_byte;
         end
      end
   end

endmodule

// ----- src/ifp_queue.sv -----
// Small queue of pending report snapshots between front and back end.
// Uses rpt_type from ifp_pkg.
module ifp_queue import ifp_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rpt_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output rpt_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rpt_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (fill_ff == CNT_W'(DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/ifp_back.sv -----
// Back end: turns the report at the head of the queue into eleven
// response bytes through an output register. Uses ifp_pkg.
module ifp_back import ifp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  rpt_type head_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic [3:0] pos_ff, pos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_payload_ff, rsp_payload_in;
   logic       load;
   logic [7:0] id_byte;
   logic [7:0] sum_byte;
   logic [7:0] cur_byte;

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && (pos_ff == POS_TAIL);

   always_comb begin
      case (head_data.kind)
         MODE_ACCEL: id_byte = ID_ACCEL;
         MODE_RATE:  id_byte = ID_RATE;
         default:    id_byte = ID_ANGLE;
      endcase
   end

   assign sum_byte = head_data.data[7:0]   + head_data.data[15:8]
                   + head_data.data[23:16] + head_data.data[31:24]
                   + head_data.data[39:32] + head_data.data[47:40];

   always_comb begin
      case (pos_ff)
         POS_HDR:  cur_byte = HDR_BYTE;
         POS_ID:   cur_byte = id_byte;
         POS_LEN:  cur_byte = LEN_BYTE;
         POS_D0:   cur_byte = head_data.data[7:0];
         POS_D1:   cur_byte = head_data.data[15:8];
         POS_D2:   cur_byte = head_data.data[23:16];
         POS_D3:   cur_byte = head_data.data[31:24];
         POS_D4:   cur_byte = head_data.data[39:32];
         POS_D5:   cur_byte = head_data.data[47:40];
         POS_SUM:  cur_byte = sum_byte;
         default:  cur_byte = TAIL_BYTE;
      endcase
   end

   always_comb begin
      pos_in         = pos_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.tx_byte   = cur_byte;
         rsp_payload_in.last_byte = (pos_ff == POS_TAIL);
         pos_in = (pos_ff == POS_TAIL) ? POS_HDR : pos_ff + 4'd1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_HDR;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- src/imu_frame_parser_and_reporter.sv -----
// IMU frame parser and reporter. Received bytes are taken one per cycle and
// give no response; they stall only while the report queue is full. A report
// request is snapshotted into a queue of QUEUE_DEPTH entries; its first byte
// passes through the queue and then the output register, and its eleven bytes
// leave one per cycle while rsp_stall is low, so the output port sets the rate.
// Synchronous reset clears the byte count, the three value stores, the queue
// and the output valid.
module imu_frame_parser_and_reporter import ifp_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    q_full;
   logic    q_push;
   rpt_type q_push_data;
   logic    q_pop;
   logic    q_head_valid;
   rpt_type q_head_data;

   ifp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   ifp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   ifp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head_data   (q_head_data),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
